// File: rtl/rcst_pkg.sv
// ----------------------------------------------------------------------------
// rcst_pkg
// Field widths, the status codes and the table entry layout shared by the
// segment table, its channel interfaces and its page rounding unit.
// ----------------------------------------------------------------------------
package rcst_pkg;

  localparam int ID_W    = 32;
  localparam int FRAME_W = 32;
  localparam int ADDR_W  = 31;
  localparam int REFS_W  = 8;
  localparam int SLOT_W  = 6;
  localparam int STAT_W  = 3;

  // largest byte address that the virtual address field can hold
  localparam int ADDR_MAX = 32'h7FFF_FFFF;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_ATTACHED = 3'd0,
    ST_CREATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_INUSE    = 3'd3,
    ST_FREED    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_INVALID  = 3'd6
  } status_t;

  typedef enum logic [0:0] {
    MODE_OPEN  = 1'b0,
    MODE_CLOSE = 1'b1
  } mode_t;

  // one table entry; an id of zero marks a free entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [FRAME_W-1:0] frame;
    logic [REFS_W-1:0]  refs;
  } entry_t;

endpackage

// File: rtl/rcst_req_if.sv
// ----------------------------------------------------------------------------
// rcst_req_if
// Request channel: open or close of a shared segment.
// ----------------------------------------------------------------------------
interface rcst_req_if import rcst_pkg::*;;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [ID_W-1:0]    seg_id;
  logic [FRAME_W-1:0] new_frame;
  logic [ADDR_W-1:0]  proc_size;

  modport source (output valid, output mode, output seg_id, output new_frame,
                  output proc_size, input ready);
  modport sink   (input valid, input mode, input seg_id, input new_frame,
                  input proc_size, output ready);
endinterface

// File: rtl/rcst_rsp_if.sv
// ----------------------------------------------------------------------------
// rcst_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface rcst_rsp_if import rcst_pkg::*;;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  slot;
  logic [FRAME_W-1:0] frame;
  logic [ADDR_W-1:0]  virt_addr;
  logic [REFS_W-1:0]  ref_count;

  modport source (output valid, output status, output slot, output frame,
                  output virt_addr, output ref_count, input ready);
  modport sink   (input valid, input status, input slot, input frame,
                  input virt_addr, input ref_count, output ready);
endinterface

// File: rtl/rcst_page_round.sv
// ----------------------------------------------------------------------------
// rcst_page_round
// Rounds a byte size up to a multiple of the page size, saturating at the
// largest page multiple that fits the address field. The page count comes
// from a multiplication by a fixed reciprocal, exact for any 32-bit biased
// size; the biased size, the page count and the address are registered in turn.
// ----------------------------------------------------------------------------
module rcst_page_round import rcst_pkg::*; #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] size,
  output logic              busy,
  output logic [ADDR_W-1:0] addr
);

  // floor(n / PAGE_BYTES) for any n below 2^32 is (n * RECIP) >> QSH
  localparam int          PL    = $clog2(PAGE_BYTES);
  localparam int          QSH   = 32 + PL;
  localparam int          QW    = 65 - QSH;
  localparam logic [32:0] RECIP = 33'(((64'd1 << QSH) / 64'(PAGE_BYTES)) + 64'd1);
  localparam logic [33:0] PB    = 34'(PAGE_BYTES);
  localparam logic [33:0] CAP   = 34'((ADDR_MAX / PAGE_BYTES) * PAGE_BYTES);
  localparam logic [31:0] BIAS  = 32'(PAGE_BYTES - 1);

  logic [31:0]   total;
  logic [QW-1:0] quot;
  logic          second;

  logic [31:0]   sum;
  logic [64:0]   prod;
  logic [33:0]   rounded;

  // bias the size, scale by the reciprocal, rebuild the page multiple
  always_comb begin
    sum     = {1'b0, size} + BIAS;
    prod    = {33'd0, total} * {32'd0, RECIP};
    rounded = 34'(quot) * PB;
  end

  // control: a page count step, then an address step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      second <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      second <= 1'b0;
    end else if (busy) begin
      second <= 1'b1;
      if (second) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: hold the biased size, take the page count, then the address
  always_ff @(posedge clk) begin
    if (start) begin
      total <= sum;
    end else if (busy) begin
      if (!second) begin
        quot <= prod[64:QSH];
      end else begin
        addr <= (rounded > CAP) ? CAP[ADDR_W-1:0] : rounded[ADDR_W-1:0];
      end
    end
  end

endmodule

// File: rtl/refcounted_segment_table.sv
// ----------------------------------------------------------------------------
// refcounted_segment_table
// Reference-counted table of shared segments held in one synchronous RAM.
// ----------------------------------------------------------------------------
// A request with a nonzero id takes one table scan: the RAM is read one entry
// per cycle from slot 0, stopping at the first entry whose id matches and
// noting the lowest free entry on the way, then the entry is updated in one
// write where the result calls for it. A request with id zero skips the scan
// and waits for the page rounding of the virtual address. One request is in
// flight at a time; the finished response sits in an output register, so the
// next request is taken while it waits, and a response still waiting there
// holds back the update of the next one. After reset the block sweeps every
// entry of the RAM to zero before it accepts the first request.
// ----------------------------------------------------------------------------
module refcounted_segment_table import rcst_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic   clk,
  input  logic   rst,
  rcst_req_if.sink   req,
  rcst_rsp_if.source rsp
);

  localparam int            AW   = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EVAL  = 4'b1000
  } state_t;

  state_t state;

  // table storage
  entry_t mem [ENTRIES];
  entry_t rd_q;
  logic          rd_en;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;

  // latched request
  logic               q_mode;
  logic [ID_W-1:0]    q_id;
  logic [FRAME_W-1:0] q_frame;
  logic               bad_id;

  // scan tracking
  logic [AW-1:0]      issue_addr;
  logic               issue_done;
  logic               chk_valid;
  logic [AW-1:0]      chk_addr;
  logic               hit;
  logic [AW-1:0]      hit_addr;
  logic [FRAME_W-1:0] hit_frame;
  logic [REFS_W-1:0]  hit_refs;
  logic               free_found;
  logic [AW-1:0]      free_addr;
  logic [AW-1:0]      clr_addr;

  // response register
  logic               out_valid;
  status_t            out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [FRAME_W-1:0] out_frame;
  logic [ADDR_W-1:0]  out_vaddr;
  logic [REFS_W-1:0]  out_refs;

  // page rounding unit
  logic              rnd_start;
  logic              rnd_busy;
  logic [ADDR_W-1:0] rnd_addr;

  // evaluation results
  logic               accept;
  logic               eval_go;
  logic               chk_match;
  status_t            e_status;
  logic [AW-1:0]      e_addr;
  logic [FRAME_W-1:0] e_frame;
  logic               e_vaddr_en;
  logic [REFS_W-1:0]  e_refs;
  logic               e_used;
  logic               e_we;
  entry_t             e_wd;
  logic [AW+SLOT_W-1:0] slot_ext;

  rcst_page_round #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_round (
    .clk   (clk),
    .rst   (rst),
    .start (rnd_start),
    .size  (req.proc_size),
    .busy  (rnd_busy),
    .addr  (rnd_addr)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rnd_start = accept;
  assign rd_en     = (state == S_SCAN) && !issue_done;
  assign chk_match = chk_valid && (rd_q.id == q_id);
  assign eval_go   = (state == S_EVAL) && !rnd_busy && (!out_valid || rsp.ready);

  // work out the response and the write-back of the entry
  always_comb begin
    e_status   = ST_INVALID;
    e_addr     = hit_addr;
    e_frame    = hit_frame;
    e_vaddr_en = 1'b0;
    e_refs     = '0;
    e_used     = 1'b0;
    e_we       = 1'b0;
    e_wd       = '0;
    if (bad_id) begin
      e_status = ST_INVALID;
    end else if (q_mode == MODE_OPEN) begin
      if (hit) begin
        e_used = 1'b1;
        if (hit_refs == REFS_MAX) begin
          e_status = ST_INVALID;
          e_refs   = REFS_MAX;
        end else begin
          e_status   = ST_ATTACHED;
          e_refs     = hit_refs + REFS_W'(1);
          e_vaddr_en = 1'b1;
          e_we       = 1'b1;
          e_wd       = '{id: q_id, frame: hit_frame, refs: e_refs};
        end
      end else if (free_found) begin
        e_status   = ST_CREATED;
        e_used     = 1'b1;
        e_addr     = free_addr;
        e_frame    = q_frame;
        e_refs     = REFS_W'(1);
        e_vaddr_en = 1'b1;
        e_we       = 1'b1;
        e_wd       = '{id: q_id, frame: q_frame, refs: REFS_W'(1)};
      end else begin
        e_status = ST_FULL;
      end
    end else begin
      if (!hit) begin
        e_status = ST_NOTFOUND;
      end else if (hit_refs <= REFS_W'(1)) begin
        e_status = ST_FREED;
        e_used   = 1'b1;
        e_we     = 1'b1;
        e_wd     = '0;
      end else begin
        e_status = ST_INUSE;
        e_used   = 1'b1;
        e_refs   = hit_refs - REFS_W'(1);
        e_we     = 1'b1;
        e_wd     = '{id: q_id, frame: hit_frame, refs: e_refs};
      end
    end
    slot_ext = {{SLOT_W{1'b0}}, e_addr};
  end

  // select the RAM write: clearing sweep or entry update
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else begin
      mem_we = eval_go && e_we;
      mem_wa = e_addr;
      mem_wd = e_wd;
    end
  end

  // RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem[issue_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      chk_valid  <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          chk_valid  <= 1'b0;
          issue_done <= 1'b0;
          if (accept) begin
            state <= (req.seg_id == '0) ? S_EVAL : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en && issue_addr == LAST) begin
            issue_done <= 1'b1;
          end
          if (chk_match || (chk_valid && chk_addr == LAST)) begin
            state     <= S_EVAL;
            chk_valid <= 1'b0;
          end else begin
            chk_valid <= rd_en;
          end
        end
        S_EVAL: begin
          if (eval_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // capture the request and track the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mode     <= req.mode;
      q_id       <= req.seg_id;
      q_frame    <= req.new_frame;
      bad_id     <= (req.seg_id == '0);
      issue_addr <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_SCAN) begin
      if (rd_en) begin
        issue_addr <= issue_addr + AW'(1);
      end
      chk_addr <= issue_addr;
      if (chk_match) begin
        hit       <= 1'b1;
        hit_addr  <= chk_addr;
        hit_frame <= rd_q.frame;
        hit_refs  <= rd_q.refs;
      end else if (chk_valid && rd_q.id == '0 && !free_found) begin
        free_found <= 1'b1;
        free_addr  <= chk_addr;
      end
    end
  end

  // response register: load on evaluation, drop on a completed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eval_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_go) begin
      out_status <= e_status;
      out_slot   <= e_used ? slot_ext[SLOT_W-1:0] : '0;
      out_frame  <= e_used ? e_frame : '0;
      out_vaddr  <= e_vaddr_en ? rnd_addr : '0;
      out_refs   <= e_refs;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.slot      = out_slot;
  assign rsp.frame     = out_frame;
  assign rsp.virt_addr = out_vaddr;
  assign rsp.ref_count = out_refs;

  // the RAM is written only by the clearing sweep or an entry update
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_EVAL))
    else $error("table written outside clear or update");

  // no request is taken before the clearing sweep has finished
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request accepted during clearing sweep");

  // a new response appears only after an evaluation
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_EVAL))
    else $error("response raised outside evaluation");

  // a checked read always refers to a slot of the table
  a_chk_range: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (state == S_SCAN && chk_addr <= LAST))
    else $error("read data checked outside the scan");

endmodule
